// ===== hdl/mcstg_pkg.sv =====
`timescale 1ns / 1ps

package mcstg_pkg;

    // Command codes carried in the opcode field
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DONE
    } t_state;

    // Per-channel dynamic state seen by the step unit
    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  pos;
        logic        dir;
        logic        step;
    } t_chan;

    localparam logic [7:0] MAX_POS_RESET = 8'd158;

endpackage

// ===== hdl/mcstg_step_unit.sv =====
`timescale 1ns / 1ps

// One channel's tick update: count, compare, head move, level toggle.
module mcstg_step_unit
    import mcstg_pkg::*;
(
    input  logic [15:0] i_period,
    input  logic [7:0]  i_max_pos,
    input  t_chan       i_cur,
    output t_chan       o_nxt
);

    logic [15:0] cnt_inc;
    logic        dir_new;

    assign cnt_inc = i_cur.count + 16'd1;

    always_comb begin
        o_nxt   = i_cur;
        dir_new = i_cur.dir;
        if (i_cur.pos >= i_max_pos) begin
            dir_new = 1'b1;
        end else if (i_cur.pos == 8'd0) begin
            dir_new = 1'b0;
        end
        if (i_period != 16'd0) begin
            if (cnt_inc >= i_period) begin
                o_nxt.count = 16'd0;
                o_nxt.dir   = dir_new;
                o_nxt.pos   = dir_new ? (i_cur.pos - 8'd1) : (i_cur.pos + 8'd1);
                o_nxt.step  = ~i_cur.step;
            end else begin
                o_nxt.count = cnt_inc;
            end
        end
    end

endmodule

// ===== hdl/multi_channel_stepper_tone_generator.sv =====
`timescale 1ns / 1ps

// Stepper tone generator, NUM_CHANNELS channels (1 to 8). Each input beat is
// a command: tick, set channel period, or reset all channels; every command
// returns one output beat with the step and direction pin levels after it.
// On a tick a small sequencer walks the channels one per cycle through a
// single shared step unit (count, compare, head move), then loads the output
// register once the output slot is free. Set, clear and unused codes go to
// the output load. o_stall is high while a command is in progress; the
// output register lets the next command be accepted while a result still
// waits on i_stall. The head turnaround register (reset 158) is written on the
// cfg channel, which is always ready; write it only while the block is idle.
// Channel for set is drive_address/2 - 1; out-of-range channels are ignored.
// Output bits at or above NUM_CHANNELS read 0.
module multi_channel_stepper_tone_generator
    import mcstg_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_drive_address,
    input  logic [15:0] i_period,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_step_levels,
    output logic [7:0]  o_direction_levels,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // channel state
    logic [15:0] r_period [NUM_CHANNELS];
    logic [15:0] r_count  [NUM_CHANNELS];
    logic [7:0]  r_pos    [NUM_CHANNELS];
    logic        r_dir    [NUM_CHANNELS];
    logic        r_step   [NUM_CHANNELS];
    logic [7:0]  r_max_pos;

    // sequencer
    t_state      r_state, n_state;
    logic [CH_W-1:0] r_chan, n_chan;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_step_out, r_dir_out;

    // control from the sequencer
    logic        set_en, clear_en, tick_en, load_out;
    logic        accept, slot_free;
    logic [6:0]  set_ch;
    logic        set_ok;

    t_chan       cur_chan, nxt_chan;
    logic [7:0]  step_pack, dir_pack;

    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign slot_free   = !r_out_valid || !i_stall;
    assign o_cfg_ready = 1'b1;

    // Set decode: addresses 0 and 1 map below channel 0 and are dropped
    assign set_ch = 7'(i_drive_address[7:1] - 7'd1);
    assign set_ok = (i_drive_address >= 8'd2) && (set_ch < 7'(NUM_CHANNELS));

    // Shared step unit sees the channel under the sequencer pointer
    assign cur_chan.count = r_count[r_chan];
    assign cur_chan.pos   = r_pos[r_chan];
    assign cur_chan.dir   = r_dir[r_chan];
    assign cur_chan.step  = r_step[r_chan];

    mcstg_step_unit u_step (
        .i_period  (r_period[r_chan]),
        .i_max_pos (r_max_pos),
        .i_cur     (cur_chan),
        .o_nxt     (nxt_chan)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chan  <= '0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    // Next state and control
    always_comb begin
        n_state  = r_state;
        n_chan   = r_chan;
        set_en   = 1'b0;
        clear_en = 1'b0;
        tick_en  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DONE;
                    case (t_op'(i_opcode))
                        OP_TICK: begin
                            n_state = ST_TICK;
                            n_chan  = '0;
                        end
                        OP_SET: begin
                            set_en = set_ok;
                        end
                        OP_CLEAR: begin
                            clear_en = 1'b1;
                        end
                        default: begin
                            // unused code: levels returned unchanged
                        end
                    endcase
                end
            end
            ST_TICK: begin
                tick_en = 1'b1;
                n_chan  = CH_W'(r_chan + 1'b1);
                if (r_chan == CH_W'(NUM_CHANNELS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // wait for the output slot, then snapshot the pin levels
                if (slot_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Channel state and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pos <= MAX_POS_RESET;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_period[c] <= 16'd0;
                r_count[c]  <= 16'd0;
                r_pos[c]    <= 8'd0;
                r_dir[c]    <= 1'b0;
                r_step[c]   <= 1'b1;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_pos <= i_cfg_data;
            end
            if (set_en) begin
                r_period[set_ch[CH_W-1:0]] <= i_period;
            end
            // clear keeps the tick counts
            if (clear_en) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_period[c] <= 16'd0;
                    r_pos[c]    <= 8'd0;
                    r_dir[c]    <= 1'b0;
                    r_step[c]   <= 1'b0;
                end
            end
            if (tick_en) begin
                r_count[r_chan] <= nxt_chan.count;
                r_pos[r_chan]   <= nxt_chan.pos;
                r_dir[r_chan]   <= nxt_chan.dir;
                r_step[r_chan]  <= nxt_chan.step;
            end
        end
    end

    // Pack pin levels; bits above the channel count stay 0
    always_comb begin
        step_pack = '0;
        dir_pack  = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            step_pack[c] = r_step[c];
            dir_pack[c]  = r_dir[c];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_step_out <= step_pack;
            r_dir_out  <= dir_pack;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_step_levels      = r_step_out;
    assign o_direction_levels = r_dir_out;

endmodule

// ===== hdl/mcstg_checker.sv =====
`timescale 1ns / 1ps

module mcstg_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_step_levels,
    input logic [7:0]  o_direction_levels
);

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result beat dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_step_levels) && $stable(o_direction_levels)))
        else $error("stalled result payload changed");

    // a command in progress blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("command accepted back to back");

    // unused channel bits read zero
    a_unused_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (((o_step_levels >> NUM_CHANNELS) == 8'd0)
                  && ((o_direction_levels >> NUM_CHANNELS) == 8'd0)))
        else $error("level bit set for a missing channel");

endmodule

bind multi_channel_stepper_tone_generator mcstg_checker #(
    .NUM_CHANNELS(NUM_CHANNELS)
) u_mcstg_checker (.*);

// ===== dv/tb_multi_channel_stepper_tone_generator.sv =====
`timescale 1ns / 1ps

module tb_multi_channel_stepper_tone_generator;
    import mcstg_pkg::*;

    localparam int NUM_CH = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;    // no-op code, returns levels
    localparam int IDLE_LIMIT = 3000;           // cycles with no beat at all
    localparam int LONG_HOLD = 400;             // one long result back-pressure
    localparam int N_DIR = 23;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [7:0]  i_drive_address;
    logic [15:0] i_period;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_step_levels;
    logic [7:0]  o_direction_levels;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    multi_channel_stepper_tone_generator #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_drive_address    (i_drive_address),
        .i_period           (i_period),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_step_levels      (o_step_levels),
        .o_direction_levels (o_direction_levels),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    // Pin levels of one result beat
    typedef struct packed {
        logic [7:0] steps;
        logic [7:0] dirs;
    } t_pins;

    // One directed command; known rows carry the pin levels typed in
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  addr;
        logic [15:0] per;
        logic        known;
        logic [7:0]  steps;
        logic [7:0]  dirs;
    } t_dir_row;

    // Local copy of the channel state
    logic [15:0] chan_period [NUM_CH];
    logic [15:0] tick_cnt    [NUM_CH];
    logic [7:0]  head_pos    [NUM_CH];
    logic        head_dir    [NUM_CH];
    logic        step_lvl    [NUM_CH];
    logic [7:0]  max_pos;

    t_pins pins_q [$];          // pin levels still owed by the block
    int    errors = 0;
    int    cur_phase = -1;      // -1 directed, then random phase index
    int    burst_left = 0;
    int    idle_cycles = 0;

    // Directed commands: ignored addresses, edge channels, lowered period,
    // clear, unused code. Levels after reset are steps all 1, dirs all 0.
    t_dir_row dir_rows [N_DIR] = '{
        '{OP_TICK,   8'd0,   16'h0000, 1'b1, 8'hFF, 8'h00},
        '{OP_UNUSED, 8'hFF,  16'hFFFF, 1'b1, 8'hFF, 8'h00},
        '{OP_SET,    8'd0,   16'h0005, 1'b1, 8'hFF, 8'h00},  // addr below 2
        '{OP_SET,    8'd1,   16'hFFFF, 1'b1, 8'hFF, 8'h00},
        '{OP_SET,    8'd18,  16'h0001, 1'b1, 8'hFF, 8'h00},  // channel 8
        '{OP_SET,    8'd255, 16'h0001, 1'b1, 8'hFF, 8'h00},
        '{OP_SET,    8'd2,   16'h0001, 1'b1, 8'hFF, 8'h00},  // ch0 every tick
        '{OP_SET,    8'd17,  16'hFFFF, 1'b1, 8'hFF, 8'h00},  // ch7 longest
        '{OP_SET,    8'd6,   16'h0003, 1'b1, 8'hFF, 8'h00},  // ch2
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_SET,    8'd6,   16'h0010, 1'b0, 8'h00, 8'h00},
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_SET,    8'd7,   16'h0001, 1'b0, 8'h00, 8'h00},  // period below count
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_SET,    8'd4,   16'hAAAA, 1'b0, 8'h00, 8'h00},
        '{OP_CLEAR,  8'h55,  16'h5555, 1'b1, 8'h00, 8'h00},
        '{OP_TICK,   8'd0,   16'h0000, 1'b1, 8'h00, 8'h00},
        '{OP_SET,    8'd16,  16'h0002, 1'b0, 8'h00, 8'h00},  // ch7 again
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00},
        '{OP_TICK,   8'd0,   16'h0000, 1'b0, 8'h00, 8'h00}
    };

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the channel model by one command and return the pin levels.
    task automatic tone_step_predict(input logic [1:0] op, input logic [7:0] addr,
                                     input logic [15:0] per, output t_pins pins);
        int c;
        int ch;
        case (op)
            OP_TICK: begin
                for (c = 0; c < NUM_CH; c++) begin
                    if (chan_period[c] != 16'd0) begin
                        tick_cnt[c] = tick_cnt[c] + 16'd1;
                        if (tick_cnt[c] >= chan_period[c]) begin
                            // turn around at the top first, then at zero
                            if (head_pos[c] >= max_pos)
                                head_dir[c] = 1'b1;
                            else if (head_pos[c] == 8'd0)
                                head_dir[c] = 1'b0;
                            head_pos[c] = head_dir[c] ? head_pos[c] - 8'd1
                                                      : head_pos[c] + 8'd1;
                            step_lvl[c] = ~step_lvl[c];
                            tick_cnt[c] = 16'd0;
                        end
                    end
                end
            end
            OP_SET: begin
                if (addr >= 8'd2) begin
                    ch = int'(addr >> 1) - 1;
                    if (ch < NUM_CH)
                        chan_period[ch] = per;
                end
            end
            OP_CLEAR: begin
                // tick counts survive a clear
                for (c = 0; c < NUM_CH; c++) begin
                    chan_period[c] = 16'd0;
                    head_pos[c] = 8'd0;
                    head_dir[c] = 1'b0;
                    step_lvl[c] = 1'b0;
                end
            end
            default: ;
        endcase
        pins = '0;
        for (c = 0; c < NUM_CH; c++) begin
            pins.steps[c] = step_lvl[c];
            pins.dirs[c] = head_dir[c];
        end
    endtask

    // Offer one command beat, honoring the burst/gap pattern of the sender.
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] addr,
                            input logic [15:0] per, input logic known,
                            input t_pins typed);
        int gap;
        t_pins pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_opcode = op;
        i_drive_address = addr;
        i_period = per;
        do @(posedge i_clk); while (o_stall);
        tone_step_predict(op, addr, per, pred);
        pins_q.push_back(known ? typed : pred);
        burst_left--;
    endtask

    // Stop sending and wait until every owed result beat has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        burst_left = 0;
        while (pins_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);   // tick sequencer may still be winding down
    endtask

    task automatic write_max_pos(input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        max_pos = val;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Result side back-pressure: random modes, stretches with no stall, and
    // one long hold early in the second random phase to fill the block up.
    initial begin : result_stall
        int hold_left;
        int mode;
        int mode_left;
        logic did_hold;
        hold_left = 0;
        mode = 0;
        mode_left = 0;
        did_hold = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else if (!did_hold && cur_phase == 1) begin
                did_hold = 1'b1;
                hold_left = LONG_HOLD - 1;
                i_stall = 1'b1;
            end else begin
                case (mode)
                    0: i_stall = 1'b0;
                    1: i_stall = ($urandom_range(0, 9) < 3);
                    2: i_stall = ($urandom_range(0, 9) < 7);
                    default: i_stall = ~i_stall;
                endcase
            end
        end
    end

    // Scoreboard: each result beat against the oldest owed levels
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pins_q.size() == 0) begin
                $error("result beat with nothing owed: steps %h dirs %h",
                       o_step_levels, o_direction_levels);
                errors++;
            end else begin
                if (o_step_levels !== pins_q[0].steps) begin
                    $error("step_levels: expected %h, actual %h",
                           pins_q[0].steps, o_step_levels);
                    errors++;
                end
                if (o_direction_levels !== pins_q[0].dirs) begin
                    $error("direction_levels: expected %h, actual %h",
                           pins_q[0].dirs, o_direction_levels);
                    errors++;
                end
                void'(pins_q.pop_front());
            end
        end
    end

    // Watchdog on cycles without any beat on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int i;
        int n;
        int r;
        int p;
        logic [1:0]  op;
        logic [7:0]  addr;
        logic [15:0] per;
        logic [7:0]  phase_max [6];
        int          phase_items [6];
        logic        phase_clear [6];

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_TICK;
        i_drive_address = 8'd0;
        i_period = 16'd0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 8'd0;
        max_pos = MAX_POS_RESET;
        for (i = 0; i < NUM_CH; i++) begin
            chan_period[i] = 16'd0;
            tick_cnt[i] = 16'd0;
            head_pos[i] = 8'd0;
            head_dir[i] = 1'b0;
            step_lvl[i] = 1'b1;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (i = 0; i < N_DIR; i++)
            send_cmd(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].per,
                     dir_rows[i].known, {dir_rows[i].steps, dir_rows[i].dirs});
        drain_results();

        // Random phases. Zero wraps heads down through 255; the 255 phase
        // runs without clears so heads can climb all the way up.
        phase_max[0] = 8'd0;                     phase_items[0] = 250;
        phase_max[1] = 8'd255;                   phase_items[1] = 450;
        phase_max[2] = 8'd1;                     phase_items[2] = 200;
        phase_max[3] = 8'($urandom_range(2, 12)); phase_items[3] = 250;
        phase_max[4] = 8'($urandom_range(0, 255)); phase_items[4] = 250;
        phase_max[5] = MAX_POS_RESET;            phase_items[5] = 250;
        for (p = 0; p < 6; p++)
            phase_clear[p] = (p != 1);

        for (p = 0; p < 6; p++) begin
            write_max_pos(phase_max[p]);
            cur_phase = p;
            for (n = 0; n < phase_items[p]; n++) begin
                r = $urandom_range(0, 99);
                addr = 8'($urandom);
                per = 16'($urandom);
                if (r < 55) begin
                    op = OP_TICK;
                end else if (r < 86) begin
                    // well-formed set on a real channel, mostly short periods
                    op = OP_SET;
                    addr = 8'(2 * $urandom_range(1, NUM_CH) + $urandom_range(0, 1));
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: per = 16'($urandom_range(1, 4));
                        6: per = 16'd0;
                        7: per = 16'($urandom_range(5, 40));
                        default: ;
                    endcase
                end else if (r < 94) begin
                    op = OP_SET;                 // any address, any period
                end else if (r < 97 || !phase_clear[p]) begin
                    op = OP_UNUSED;
                end else begin
                    op = OP_CLEAR;
                end
                send_cmd(op, addr, per, 1'b0, '0);
            end
            // sender pauses here until everything owed has come back
            drain_results();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
